### rtl/pwlti_pkg.sv
// Shared types and constants for the piecewise linear table interpolator.
`default_nettype none
package pwlti_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = IDX_W + 1;
   localparam int VAL_W       = 32;
   localparam int REQ_DATA_W  = 104;
   localparam int RSP_USER_W  = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_INSIDE = 2'd0,
      ST_BELOW  = 2'd1,
      ST_EXTRA  = 2'd2,
      ST_EQUAL  = 2'd3
   } status_type;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_CHK0 = 12'b000000000010,
      S_CHKL = 12'b000000000100,
      S_SRCH = 12'b000000001000,
      S_SCMP = 12'b000000010000,
      S_FLO  = 12'b000000100000,
      S_FHI  = 12'b000001000000,
      S_DIFF = 12'b000010000000,
      S_MUL  = 12'b000100000000,
      S_DST  = 12'b001000000000,
      S_DIV  = 12'b010000000000,
      S_FIN  = 12'b100000000000
   } state_type;
endpackage
`default_nettype wire

### rtl/pwlti_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module pwlti_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/pwlti_div.sv
// Restoring serial divider, 64 by 32 bits, one quotient bit per cycle.
`default_nettype none
module pwlti_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   import pwlti_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### rtl/piecewise_linear_table_interp_top.sv
// Top level of the piecewise linear table interpolator.
//
// channel | dir | ports           | beat carries
// req     | in  | req_t*          | table write or query
// rsp     | out | rsp_t*          | one result per query
// csr     | in  | csr_valid/ready | table_length
//
// A query's run time is set by the serial divider at one bit a cycle and the
// single table read port used by the binary search. Reset is synchronous and
// clears control only; the table is undefined until written. A finished
// result waits in the output register while the next beat is taken; a query
// ending while it still waits holds in its last state.
`default_nettype none
module piecewise_linear_table_interp_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] entry_index, [39:8] entry_x, [71:40] entry_y, [103:72] query_position
   input  wire logic [pwlti_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] opcode
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [31:0] interp_value
   output logic [pwlti_pkg::VAL_W-1:0]             rsp_tdata,
   // [1:0] status, [2] saturated
   output logic [pwlti_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [pwlti_pkg::LEN_W-1:0]        csr_data
);
   import pwlti_pkg::*;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  tlen_ff;
   logic [LEN_W-1:0]  len;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [LEN_W-1:0]  mid_sum;
   logic [IDX_W-1:0]  mid;
   logic [IDX_W-1:0]  rd_addr;
   logic [63:0]       ram_q;
   logic signed [31:0] ram_x, ram_y;
   logic signed [31:0] pos_ff;
   logic signed [31:0] x0_ff, y0_ff;
   logic [31:0]       mdy_ff, mdp_ff, mdx_ff;
   logic              neg_ff;
   logic [63:0]       prod_ff;
   logic [31:0]       res_val_ff, res_val_in;
   status_type        res_st_ff, res_st_in;
   logic              res_sat_ff, res_sat_in;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_val_ff;
   status_type        rsp_st_ff;
   logic              rsp_sat_ff;
   logic              accept;
   logic              wr_en;
   logic              div_done;
   logic [63:0]       quo;
   logic signed [32:0] dx, dy, dp;
   logic [34:0]       sum35;
   logic [34:0]       q35;
   logic              q_big;
   logic              out_free;

   assign len = (tlen_ff < LEN_W'(2)) ? LEN_W'(2) :
                (tlen_ff > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : tlen_ff;
   assign last_idx = IDX_W'(len - LEN_W'(1));
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[LEN_W-1:1];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (req_tuser == OP_WRITE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Read address follows the sequencer; the RAM registers the read, so data arrives in the next cycle.
   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = '0;
         S_CHK0:  rd_addr = last_idx;
         S_SRCH:  rd_addr = mid;
         S_FLO:   rd_addr = lo_ff;
         S_FHI:   rd_addr = hi_ff;
         default: rd_addr = lo_ff;
      endcase
   end

   pwlti_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_tdata[IDX_W-1:0]),
      .wr_data ({req_tdata[71:40], req_tdata[39:8]}),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );
   assign ram_x = ram_q[31:0];
   assign ram_y = ram_q[63:32];

   pwlti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DST),
      .dividend (prod_ff),
      .divisor  (mdx_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign dx = {ram_x[31], ram_x} - {x0_ff[31], x0_ff};
   assign dy = {ram_y[31], ram_y} - {y0_ff[31], y0_ff};
   assign dp = {pos_ff[31], pos_ff} - {x0_ff[31], x0_ff};

   // Final add: y0 +/- q, clipped to 32 bits. q above 2^33 always clips.
   assign q_big = (quo[63:34] != '0) || (quo[33] && (quo[32:0] != '0));
   assign q35   = {1'b0, quo[33:0]};
   assign sum35 = {{3{y0_ff[31]}}, y0_ff} + (neg_ff ? (~q35 + 35'd1) : q35);

   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      res_val_in = res_val_ff;
      res_st_in  = res_st_ff;
      res_sat_in = res_sat_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser == OP_QUERY) begin
               state_in = S_CHK0;
            end
         end
         S_CHK0: begin
            if (pos_ff < ram_x) begin
               res_val_in = '0;
               res_st_in  = ST_BELOW;
               res_sat_in = 1'b0;
               state_in   = S_FIN;
            end else begin
               state_in = S_CHKL;
            end
         end
         S_CHKL: begin
            hi_in = last_idx;
            if (pos_ff >= ram_x) begin
               lo_in     = last_idx - IDX_W'(1);
               res_st_in = ST_EXTRA;
               state_in  = S_FLO;
            end else begin
               lo_in     = '0;
               res_st_in = ST_INSIDE;
               state_in  = S_SRCH;
            end
         end
         S_SRCH: begin
            if ((hi_ff - lo_ff) > IDX_W'(1)) begin
               state_in = S_SCMP;
            end else begin
               state_in = S_FLO;
            end
         end
         S_SCMP: begin
            if (ram_x <= pos_ff) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH;
         end
         S_FLO:  state_in = S_FHI;
         S_FHI:  state_in = S_DIFF;
         S_DIFF: begin
            if (dx == '0) begin
               res_val_in = '0;
               res_st_in  = ST_EQUAL;
               res_sat_in = 1'b0;
               state_in   = S_FIN;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL:  state_in = S_DST;
         S_DST:  state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               if (q_big) begin
                  res_val_in = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  res_sat_in = 1'b1;
               end else if (sum35[34:31] != {4{sum35[34]}}) begin
                  res_val_in = sum35[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  res_sat_in = 1'b1;
               end else begin
                  res_val_in = sum35[31:0];
                  res_sat_in = 1'b0;
               end
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tlen_ff      <= LEN_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            tlen_ff <= csr_data;
         end
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      res_sat_ff <= res_sat_in;
      if (accept) begin
         pos_ff <= req_tdata[103:72];
      end
      if (state_ff == S_FHI) begin
         x0_ff <= ram_x;
         y0_ff <= ram_y;
      end
      if (state_ff == S_DIFF) begin
         mdx_ff <= dx[32] ? 32'(-dx) : dx[31:0];
         mdy_ff <= dy[32] ? 32'(-dy) : dy[31:0];
         mdp_ff <= dp[32] ? 32'(-dp) : dp[31:0];
         neg_ff <= (dy[32] ^ dp[32]) ^ dx[32];
      end
      if (state_ff == S_MUL) begin
         prod_ff <= 64'(mdy_ff) * 64'(mdp_ff);
      end
      if (state_ff == S_FIN && out_free) begin
         rsp_val_ff <= res_val_ff;
         rsp_st_ff  <= res_st_ff;
         rsp_sat_ff <= res_sat_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_val_ff;
   assign rsp_tuser  = {rsp_sat_ff, rsp_st_ff};

   // Below range and equal breakpoints always give a clean zero.
   a_zero_cases: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == ST_BELOW || rsp_tuser[1:0] == ST_EQUAL)
      |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("zero result case carries a value");

   // A clipped value sits on one of the two rails.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2]
      |-> rsp_tdata == 32'h8000_0000 || rsp_tdata == 32'h7FFF_FFFF)
      else $error("saturated result off the rails");

   // The divider only finishes while the sequencer waits on it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside division phase");
endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the piecewise linear table interpolator.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import pwlti_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 120;
   localparam int N_RANDOM    = 670;
   localparam logic [31:0] ORD_BASE = 32'hC000_0000;
   localparam logic [31:0] ORD_STEP = 32'h0040_0000;

   typedef struct packed {
      logic [31:0] value;
      status_type  status;
      logic        sat;
   } interp_res_type;

   // one row of the directed stimulus; typed rows carry their own answer
   typedef struct packed {
      logic           op;
      logic [7:0]     idx;
      logic [31:0]    x;
      logic [31:0]    y;
      logic [31:0]    pos;
      logic           typed;
      interp_res_type res;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [7:0] entry_index, [39:8] entry_x, [71:40] entry_y, [103:72] query_position
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [0] opcode
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [31:0] interp_value
   logic [VAL_W-1:0]      rsp_tdata;
   // [1:0] status, [2] saturated
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [LEN_W-1:0]      csr_data = '0;

   // shadow of the breakpoint table and of table_length
   logic [31:0]     bp_x [TABLE_DEPTH];
   logic [31:0]     bp_y [TABLE_DEPTH];
   logic [8:0]      tbl_len = 9'd2;
   interp_res_type  pending_results [$];

   int unsigned cycles = 0;
   int unsigned err_count = 0;
   int unsigned n_queries = 0, n_writes = 0, n_cfg = 0, n_results = 0, n_sat = 0;
   int unsigned status_seen [4] = '{0, 0, 0, 0};
   int unsigned burst_left = 0;
   bit          idle_on = 1'b1;

   piecewise_linear_table_interp_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Value of the polyline at pos: below range gives zero, at or past the last
   // breakpoint extrapolates along the last two, otherwise binary search for
   // x[lo] <= pos < x[hi]. Product exact, quotient truncated, sum saturated.
   function automatic interp_res_type interp_at(input logic [31:0] pos_bits);
      interp_res_type r;
      int          len, lo, hi, mid;
      longint      pos, x0, x1, y0, y1, dx, dy, dp, val;
      logic [63:0] q;
      bit          neg;
      r.sat = 1'b0;
      len = (tbl_len < 2) ? 2 : (tbl_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_len);
      pos = longint'($signed(pos_bits));
      if (pos < longint'($signed(bp_x[0]))) begin
         r.value = '0; r.status = ST_BELOW;
         return r;
      end
      if (pos >= longint'($signed(bp_x[len-1]))) begin
         lo = len - 2; hi = len - 1; r.status = ST_EXTRA;
      end else begin
         lo = 0; hi = len - 1; r.status = ST_INSIDE;
         while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (longint'($signed(bp_x[mid])) <= pos) lo = mid;
            else hi = mid;
         end
      end
      x0 = $signed(bp_x[lo]); x1 = $signed(bp_x[hi]);
      y0 = $signed(bp_y[lo]); y1 = $signed(bp_y[hi]);
      dx = x1 - x0;
      if (dx == 0) begin
         r.value = '0; r.status = ST_EQUAL;
         return r;
      end
      dy = y1 - y0;
      dp = pos - x0;
      neg = ((dy < 0) != (dp < 0)) != (dx < 0);
      q = (64'(dy < 0 ? -dy : dy) * 64'(dp < 0 ? -dp : dp)) / 64'(dx < 0 ? -dx : dx);
      if (q > 64'h2_0000_0000) begin
         val = neg ? -64'sd2147483648 : 64'sd2147483647;
         r.sat = 1'b1;
      end else begin
         val = y0 + (neg ? -longint'(q) : longint'(q));
         if (val > 64'sd2147483647) begin
            val = 64'sd2147483647; r.sat = 1'b1;
         end else if (val < -64'sd2147483648) begin
            val = -64'sd2147483648; r.sat = 1'b1;
         end
      end
      r.value = val[31:0];
      return r;
   endfunction

   // Drive one request beat, hold it until taken, then account for it.
   task automatic send_beat(input logic op, input logic [7:0] idx, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] pos,
                            input bit typed = 1'b0, input interp_res_type res = '0);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pos, y, x, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_WRITE) begin
         bp_x[idx] = x; bp_y[idx] = y;
         n_writes++;
      end else begin
         pending_results.push_back(typed ? res : interp_at(pos));
         n_queries++;
      end
      // burst/gap pattern on the sender
      if (burst_left == 0) burst_left = $urandom_range(1, 24);
      burst_left--;
      if (burst_left == 0 && idle_on) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Quiesce: every result in, then let a write-free query tail settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_length(input logic [8:0] len);
      csr_valid <= 1'b1;
      csr_data  <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tbl_len = len;
      n_cfg++;
   endtask

   // Pick a query position: mostly inside the populated span, with some
   // breakpoint hits, positions just below the range, extremes and fully random values.
   function automatic logic [31:0] pick_position();
      int     len, k;
      longint lo_x, hi_x, span;
      len  = (tbl_len < 2) ? 2 : (tbl_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_len);
      lo_x = $signed(bp_x[0]);
      hi_x = $signed(bp_x[len-1]);
      span = hi_x - lo_x;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: begin
            k = $urandom_range(0, len - 1);
            return bp_x[k];
         end
         3: return bp_x[0] - 32'($urandom_range(1, 1000));
         default: begin
            if (span <= 0) return $urandom;
            return 32'(lo_x + longint'({$urandom, $urandom} % 64'(span + 64)));
         end
      endcase
   endfunction

   task automatic random_write();
      logic [7:0]  idx;
      logic [31:0] x, y;
      idx = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 5))
         0: x = $urandom;                                        // breaks the order
         1: x = (idx == 0) ? bp_x[1] : bp_x[idx-1];              // equal breakpoints
         default: x = ORD_BASE + idx * ORD_STEP + 32'($urandom_range(0, 16'hFFFF));
      endcase
      y = $urandom_range(0, 1) ? $urandom : 32'($signed(16'($urandom)));
      send_beat(OP_WRITE, idx, x, y, $urandom);
   endtask

   // Directed part, run at the reset length of two entries.
   stim_row_type directed [] = '{
      '{OP_WRITE, 8'd0, 32'h0000_0000, 32'h0000_0000, 32'h0, 1'b0, '0},
      '{OP_WRITE, 8'd1, 32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, '{32'h0, ST_BELOW, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, '{32'h0, ST_BELOW, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, '{32'h0, ST_INSIDE, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0000_8000, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, '{32'h0002_0000, ST_EXTRA, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h7FFF_FFFF, ST_EXTRA, 1'b1}},
      // equal breakpoints
      '{OP_WRITE, 8'd1, 32'h0000_0000, 32'h1234_5678, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, '{32'h0, ST_EQUAL, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h0, ST_EQUAL, 1'b0}},
      // steep segment from the bottom of the range, both saturation directions
      '{OP_WRITE, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
      '{OP_WRITE, 8'd1, 32'h8000_0001, 32'h8000_0000, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b1, '{32'h7FFF_FFFF, ST_INSIDE, 1'b0}},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, ST_EXTRA, 1'b1}},
      '{OP_WRITE, 8'd1, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0, 1'b0, '0},
      '{OP_WRITE, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0000_1234, 1'b1, '{32'h7FFF_FFFF, ST_EXTRA, 1'b1}},
      // unordered pair: both queries extrapolate from x0 > x1, and the line rises past x0
      '{OP_WRITE, 8'd0, 32'h0010_0000, 32'h0000_4000, 32'h0, 1'b0, '0},
      '{OP_WRITE, 8'd1, 32'h0008_0000, 32'hFFFF_C000, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0010_0000, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0020_0000, 1'b0, '0},
      // top slot, unused at this length
      '{OP_WRITE, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
      '{OP_QUERY, 8'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, '{32'h0, ST_BELOW, 1'b0}}
   };

   // Length settings per random phase; 0, 1 and 511 test the clamping.
   logic [8:0] phase_len [] = '{9'd256, 9'd2, 9'd3, 9'd511, 9'd0, 9'd17, 9'd1, 9'd128};

   // Receiver: stall mode follows bits 7:6 of the cycle counter, including fully ready stretches.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      case (cycles[7:6])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_tready <= ($urandom_range(0, 4) == 0);
         default: rsp_tready <= $urandom_range(0, 1);
      endcase
   end

   // Result checker: oldest expectation against each accepted beat.
   always @(posedge clock) begin
      interp_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat value=%h user=%b", $time, rsp_tdata, rsp_tuser);
            err_count++;
         end else begin
            want = pending_results.pop_front();
            n_results++;
            status_seen[want.status]++;
            if (want.sat) n_sat++;
            if (rsp_tdata !== want.value)
               $display("%0t: interp_value mismatch expected=%h actual=%h", $time, want.value,
                        rsp_tdata);
            if (rsp_tuser[1:0] !== want.status)
               $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                        rsp_tuser[1:0]);
            if (rsp_tuser[2] !== want.sat)
               $display("%0t: saturated mismatch expected=%b actual=%b", $time, want.sat,
                        rsp_tuser[2]);
            if (rsp_tdata !== want.value || rsp_tuser !== {want.sat, want.status})
               err_count++;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned k, p, per_phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_length(9'd2);
      foreach (directed[i])
         send_beat(directed[i].op, directed[i].idx, directed[i].x, directed[i].y,
                   directed[i].pos, directed[i].typed, directed[i].res);

      // populate every slot in ascending order before any longer length is used
      for (k = 0; k < TABLE_DEPTH; k++)
         send_beat(OP_WRITE, 8'(k), ORD_BASE + k * ORD_STEP, $urandom, $urandom);

      per_phase = N_RANDOM / phase_len.size();
      for (p = 0; p < phase_len.size(); p++) begin
         wait_idle();
         set_length(phase_len[p]);
         idle_on = (p % 3) != 1;    // some phases run back to back
         for (k = 0; k < per_phase; k++) begin
            if ($urandom_range(0, 9) < 3) random_write();
            else send_beat(OP_QUERY, 8'($urandom), $urandom, $urandom, pick_position());
         end
      end

      wait_idle();
      $display("Covered %0d queries, %0d table writes, %0d length settings; %0d results checked.",
               n_queries, n_writes, n_cfg, n_results);
      $display("Status mix inside/below/extrapolated/equal = %0d/%0d/%0d/%0d, %0d saturated.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], n_sat);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", err_count, pending_results.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
rtl/pwlti_pkg.sv
rtl/pwlti_ram.sv
rtl/pwlti_div.sv
rtl/piecewise_linear_table_interp_top.sv
dv/tb_top.sv
